// ===== rtl/tpsc_pkg.sv =====
`default_nettype none

package tpsc_pkg;

  // electrical period in table segments
  localparam int PERIOD_SEGMENTS = 900;

  // quarter-wave sine samples stored in the source table
  localparam int ROM_LEN = 225;

  localparam int QUARTER_LEN = PERIOD_SEGMENTS / 4;
  localparam int HALF_LEN    = PERIOD_SEGMENTS / 2;
  localparam int Q3_START    = PERIOD_SEGMENTS * 3 / 4;
  localparam int THIRD_LEN   = PERIOD_SEGMENTS / 3;

  localparam int POS_W   = 16;
  localparam int SHAMT_W = 4;
  localparam int DUTY_W  = 8;

  // segment index and remainder widths
  localparam int SEG_W  = $clog2(PERIOD_SEGMENTS);
  localparam int REM_W  = $clog2(2 * PERIOD_SEGMENTS);
  localparam int QIDX_W = $clog2(QUARTER_LEN);

  // positive bias that makes every position non-negative before reduction
  localparam int POS_BIAS = ((32768 + PERIOD_SEGMENTS - 1) / PERIOD_SEGMENTS) * PERIOD_SEGMENTS;
  localparam int U_MAX    = 32767 + POS_BIAS;
  localparam int U_W      = $clog2(U_MAX + 1);
  localparam int QUO_W    = $clog2(U_MAX / PERIOD_SEGMENTS + 1);

  // reciprocal of the period, quotient estimate is low by at most one
  localparam int                 RECIP_SH = 32;
  localparam longint unsigned    RECIP    = (64'd1 << RECIP_SH) / PERIOD_SEGMENTS;
  localparam int                 RECIP_W  = $clog2(RECIP + 1);
  localparam int                 PROD_W   = U_W + RECIP_W;

  typedef logic [DUTY_W-1:0] duty_t;
  typedef duty_t rom_t [ROM_LEN];
  typedef duty_t quarter_tab_t [QUARTER_LEN];

  localparam rom_t QUARTER_SINE = '{
    8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd132, 8'd133, 8'd134,
    8'd135, 8'd136, 8'd137, 8'd138, 8'd139, 8'd139, 8'd140, 8'd141,
    8'd142, 8'd143, 8'd144, 8'd145, 8'd146, 8'd147, 8'd147, 8'd148,
    8'd149, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd154, 8'd155,
    8'd156, 8'd157, 8'd158, 8'd159, 8'd160, 8'd160, 8'd161, 8'd162,
    8'd163, 8'd164, 8'd165, 8'd166, 8'd166, 8'd167, 8'd168, 8'd169,
    8'd170, 8'd171, 8'd172, 8'd172, 8'd173, 8'd174, 8'd175, 8'd176,
    8'd176, 8'd177, 8'd178, 8'd179, 8'd180, 8'd181, 8'd181, 8'd182,
    8'd183, 8'd184, 8'd185, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189,
    8'd189, 8'd190, 8'd191, 8'd192, 8'd192, 8'd193, 8'd194, 8'd195,
    8'd195, 8'd196, 8'd197, 8'd198, 8'd198, 8'd199, 8'd200, 8'd201,
    8'd201, 8'd202, 8'd203, 8'd204, 8'd204, 8'd205, 8'd206, 8'd206,
    8'd207, 8'd208, 8'd208, 8'd209, 8'd210, 8'd210, 8'd211, 8'd212,
    8'd212, 8'd213, 8'd214, 8'd214, 8'd215, 8'd216, 8'd216, 8'd217,
    8'd218, 8'd218, 8'd219, 8'd220, 8'd220, 8'd221, 8'd221, 8'd222,
    8'd223, 8'd223, 8'd224, 8'd224, 8'd225, 8'd225, 8'd226, 8'd227,
    8'd227, 8'd228, 8'd228, 8'd229, 8'd229, 8'd230, 8'd230, 8'd231,
    8'd231, 8'd232, 8'd232, 8'd233, 8'd233, 8'd234, 8'd234, 8'd235,
    8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd238, 8'd238, 8'd239,
    8'd239, 8'd239, 8'd240, 8'd240, 8'd241, 8'd241, 8'd242, 8'd242,
    8'd242, 8'd243, 8'd243, 8'd243, 8'd244, 8'd244, 8'd245, 8'd245,
    8'd245, 8'd246, 8'd246, 8'd246, 8'd247, 8'd247, 8'd247, 8'd247,
    8'd248, 8'd248, 8'd248, 8'd249, 8'd249, 8'd249, 8'd249, 8'd250,
    8'd250, 8'd250, 8'd250, 8'd251, 8'd251, 8'd251, 8'd251, 8'd252,
    8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd253, 8'd253, 8'd253,
    8'd253, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
    8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255
  };

  // quarter table resampled to the period, built at elaboration
  function automatic quarter_tab_t build_quarter_tab();
    quarter_tab_t tab;
    int r;
    for (int i = 0; i < QUARTER_LEN; i++) begin
      r = (i * ROM_LEN) / QUARTER_LEN;
      if (r >= ROM_LEN) begin
        r = ROM_LEN - 1;
      end
      tab[i] = QUARTER_SINE[r];
    end
    return tab;
  endfunction

  localparam quarter_tab_t QUARTER_TAB = build_quarter_tab();

  typedef struct packed {
    logic               motor_select;
    logic [SHAMT_W-1:0] attenuation;
  } side_t;

  typedef struct packed {
    logic [SEG_W-1:0] a;
    logic [SEG_W-1:0] b;
    logic [SEG_W-1:0] c;
  } seg_t;

  typedef struct packed {
    logic lookup_en;
    logic shift_en;
  } duty_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/three_phase_sine_commutation.sv =====
// three-phase sine commutation
//
// slave side takes one beat per position: s_axis_tdata carries the signed
// electrical position (segments) and the attenuation shift, s_axis_tuser the
// motor select. the position is wrapped into one electrical period and three
// duties are produced for phases at the position, plus one third and plus two
// thirds of a period, each from a mirrored quarter-wave sine table centered
// on 128 and shifted right by the attenuation (8 and up clears them).
// master side gives one beat per accepted input: three duties on
// m_axis_tdata, the motor group they belong to on m_axis_tuser.
//
// input beat to output beat runs through registered stages in this order:
// bias and reciprocal multiply, remainder, wrap, phase offsets, table lookup, shift.
// throughput is one beat per cycle; every stage has its own valid bit and
// loads whenever it is empty or the stage after it moves, so bubbles close
// up while the receiver stalls and s_axis_tready drops only once all six
// stages hold a beat. nothing is dropped or repeated under backpressure.
// reset clears the valid bits only; there is no other state and no
// clearing pass, so the block takes beats in the first cycle after reset.
`default_nettype none

module three_phase_sine_commutation
  import tpsc_pkg::*;
(
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  logic [23:0] s_axis_tdata,   // position [15:0], attenuation [19:16], zero pad
  input  wire  logic        s_axis_tuser,   // motor_select [0]
  output logic              m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // duty_phase_a [7:0], duty_phase_b [15:8],
                                            // duty_phase_c [23:16]
  output logic              m_axis_tuser    // motor_group [0]
);

  side_t     side_in;
  logic      wrap_vld;
  logic      wrap_rdy;
  seg_t      wrap_seg;
  side_t     wrap_side;

  // lookup and shift stages
  logic [1:0] d_vld_q;
  logic [1:0] d_rdy;
  side_t      side5_q;
  logic       motor6_q;
  duty_ctl_t  duty_ctl;
  duty_t      duty_a, duty_b, duty_c;

  assign side_in.motor_select = s_axis_tuser;
  assign side_in.attenuation  = s_axis_tdata[POS_W +: SHAMT_W];

  tpsc_wrap u_wrap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pos_i       (s_axis_tdata[POS_W-1:0]),
    .side_i      (side_in),
    .out_valid_o (wrap_vld),
    .out_ready_i (wrap_rdy),
    .seg_o       (wrap_seg),
    .side_o      (wrap_side)
  );

  // ready ripples back from the output register
  assign d_rdy[1] = !d_vld_q[1] || m_axis_tready;
  assign d_rdy[0] = !d_vld_q[0] || d_rdy[1];
  assign wrap_rdy = d_rdy[0];

  assign duty_ctl.lookup_en = d_rdy[0];
  assign duty_ctl.shift_en  = d_rdy[1];

  tpsc_duty u_duty_a (
    .clk_i   (clk_i),
    .ctl_i   (duty_ctl),
    .seg_i   (wrap_seg.a),
    .shamt_i (side5_q.attenuation),
    .duty_o  (duty_a)
  );

  tpsc_duty u_duty_b (
    .clk_i   (clk_i),
    .ctl_i   (duty_ctl),
    .seg_i   (wrap_seg.b),
    .shamt_i (side5_q.attenuation),
    .duty_o  (duty_b)
  );

  tpsc_duty u_duty_c (
    .clk_i   (clk_i),
    .ctl_i   (duty_ctl),
    .seg_i   (wrap_seg.c),
    .shamt_i (side5_q.attenuation),
    .duty_o  (duty_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= '0;
    end else begin
      if (d_rdy[0]) begin
        d_vld_q[0] <= wrap_vld;
      end
      if (d_rdy[1]) begin
        d_vld_q[1] <= d_vld_q[0];
      end
    end
  end

  // sideband follows the duty stages
  always_ff @(posedge clk_i) begin
    if (d_rdy[0]) begin
      side5_q <= wrap_side;
    end
    if (d_rdy[1]) begin
      motor6_q <= side5_q.motor_select;
    end
  end

  assign m_axis_tvalid = d_vld_q[1];
  assign m_axis_tdata  = {duty_c, duty_b, duty_a};
  assign m_axis_tuser  = motor6_q;

  // wrapped segments stay inside one period
  a_seg_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrap_vld |-> (wrap_seg.a < SEG_W'(PERIOD_SEGMENTS)) &&
                 (wrap_seg.b < SEG_W'(PERIOD_SEGMENTS)) &&
                 (wrap_seg.c < SEG_W'(PERIOD_SEGMENTS)))
    else $error("wrapped segment outside the period");

  // phase b leads phase c by one third of a period, modulo the period
  a_seg_spacing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrap_vld |-> ((32'(wrap_seg.b) == 32'(wrap_seg.c) + THIRD_LEN) ||
                  (32'(wrap_seg.b) + PERIOD_SEGMENTS == 32'(wrap_seg.c) + THIRD_LEN)))
    else $error("phase spacing broken");

  // a free receiver must never stall the sender
  a_ready_path : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

endmodule

`default_nettype wire

// ===== rtl/tpsc_wrap.sv =====
`default_nettype none

module tpsc_wrap
  import tpsc_pkg::*;
(
  input  wire  logic                    clk_i,
  input  wire  logic                    rst_ni,
  input  wire  logic                    in_valid_i,
  output logic                          in_ready_o,
  input  wire  logic signed [POS_W-1:0] pos_i,
  input  wire  side_t                   side_i,
  output logic                          out_valid_o,
  input  wire  logic                    out_ready_i,
  output seg_t                          seg_o,
  output side_t                         side_o
);

  localparam int NSTG = 4;

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] rdy;
  side_t           side_q [NSTG];

  // stage 1: bias and reciprocal multiply
  logic [U_W-1:0]    u_d, u_q;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo_d, quo_q;
  // stage 2: remainder below twice the period
  logic [U_W-1:0]    rem_full;
  logic [REM_W-1:0]  rem_d, rem_q;
  // stage 3: final wrap
  logic [SEG_W-1:0]  sc_d, sc_q;
  // stage 4: phase offsets
  logic [SEG_W:0]    sum_b, sum_a;
  seg_t              seg_d, seg_q;

  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  assign u_d   = U_W'(int'(pos_i) + POS_BIAS);
  assign prod  = PROD_W'(u_d) * PROD_W'(RECIP);
  assign quo_d = QUO_W'(prod >> RECIP_SH);

  assign rem_full = u_q - U_W'(U_W'(quo_q) * U_W'(PERIOD_SEGMENTS));
  assign rem_d    = REM_W'(rem_full);

  assign sc_d = (rem_q >= REM_W'(PERIOD_SEGMENTS)) ? SEG_W'(rem_q - REM_W'(PERIOD_SEGMENTS))
                                                   : SEG_W'(rem_q);

  assign sum_b = {1'b0, sc_q} + (SEG_W+1)'(THIRD_LEN);
  assign sum_a = {1'b0, sc_q} + (SEG_W+1)'(2 * THIRD_LEN);

  always_comb begin
    seg_d.c = sc_q;
    seg_d.b = (sum_b >= (SEG_W+1)'(PERIOD_SEGMENTS)) ?
              SEG_W'(sum_b - (SEG_W+1)'(PERIOD_SEGMENTS)) : SEG_W'(sum_b);
    seg_d.a = (sum_a >= (SEG_W+1)'(PERIOD_SEGMENTS)) ?
              SEG_W'(sum_a - (SEG_W+1)'(PERIOD_SEGMENTS)) : SEG_W'(sum_a);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      u_q       <= u_d;
      quo_q     <= quo_d;
      side_q[0] <= side_i;
    end
    if (rdy[1]) begin
      rem_q     <= rem_d;
      side_q[1] <= side_q[0];
    end
    if (rdy[2]) begin
      sc_q      <= sc_d;
      side_q[2] <= side_q[1];
    end
    if (rdy[3]) begin
      seg_q     <= seg_d;
      side_q[3] <= side_q[2];
    end
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign seg_o       = seg_q;
  assign side_o      = side_q[NSTG-1];

endmodule

`default_nettype wire

// ===== rtl/tpsc_duty.sv =====
`default_nettype none

module tpsc_duty
  import tpsc_pkg::*;
(
  input  wire  logic               clk_i,
  input  wire  duty_ctl_t          ctl_i,
  input  wire  logic [SEG_W-1:0]   seg_i,
  input  wire  logic [SHAMT_W-1:0] shamt_i,
  output duty_t                    duty_o
);

  logic [SEG_W-1:0] qidx;
  logic             flip;
  duty_t            sample;
  duty_t            raw_d, raw_q;
  duty_t            duty_d, duty_q;

  // fold the segment into the first quarter
  always_comb begin
    priority if (seg_i >= SEG_W'(Q3_START)) begin
      qidx = SEG_W'(PERIOD_SEGMENTS - 1) - seg_i;
      flip = 1'b1;
    end else if (seg_i >= SEG_W'(HALF_LEN)) begin
      qidx = seg_i - SEG_W'(HALF_LEN);
      flip = 1'b1;
    end else if (seg_i >= SEG_W'(QUARTER_LEN)) begin
      qidx = SEG_W'(HALF_LEN - 1) - seg_i;
      flip = 1'b0;
    end else begin
      qidx = seg_i;
      flip = 1'b0;
    end
    if (qidx >= SEG_W'(QUARTER_LEN)) begin
      qidx = SEG_W'(QUARTER_LEN - 1);
    end
  end

  assign sample = QUARTER_TAB[qidx[QIDX_W-1:0]];
  assign raw_d  = flip ? ~sample : sample;

  // shifts of a full byte or more clear the duty
  assign duty_d = (shamt_i >= SHAMT_W'(DUTY_W)) ? '0 : (raw_q >> shamt_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.lookup_en) begin
      raw_q <= raw_d;
    end
    if (ctl_i.shift_en) begin
      duty_q <= duty_d;
    end
  end

  assign duty_o = duty_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tpsc_pkg::*;

  localparam int SEGS = PERIOD_SEGMENTS;
  localparam int QTR = SEGS / 4;
  localparam int RANDOM_BEATS = 700;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic signed [15:0] position;
    logic               motor_select;
    logic [3:0]         attenuation;
    bit                 hold_for_idle;  // send only once every duty set has come back
  } position_cmd_t;

  // field order follows the struct, motor group first
  typedef struct packed {
    logic       motor_group;
    logic [7:0] duty_a;
    logic [7:0] duty_b;
    logic [7:0] duty_c;
  } duty_set_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // position [15:0], attenuation [19:16], zero pad
  logic        s_axis_tuser = 1'b0;  // motor_select [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // duty_phase_a [7:0], duty_phase_b [15:8], duty_phase_c [23:16]
  logic        m_axis_tuser;  // motor_group [0]

  position_cmd_t pending_cmds[$];
  duty_set_t     duty_forecast[$];
  int            total_cmds;
  int            accepted_beats = 0;
  int            results_owed = 0;
  int            errors = 0;
  int            quiet_cycles = 0;
  int            send_gap = 0;
  int            recv_stall = 0;
  bit            send_calm = 1'b0;
  bit            recv_calm = 1'b0;
  int            landmarks[6] = '{0, SEGS / 4, SEGS / 2, 3 * SEGS / 4, SEGS / 3, 2 * SEGS / 3};

  three_phase_sine_commutation uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // quarter-wave read, index resampled to the table and saturated at its end
  function automatic int quarter_sample(int q);
    int r;
    if (q >= QTR) q = QTR - 1;
    r = (q * ROM_LEN) / QTR;
    if (r >= ROM_LEN) r = ROM_LEN - 1;
    return int'(QUARTER_SINE[r]);
  endfunction

  // four-quadrant mirror and complement around the quarter wave
  function automatic logic [7:0] sine_duty(int s);
    if (s >= SEGS * 3 / 4) return 8'(255 - quarter_sample(SEGS - s - 1));
    if (s >= SEGS / 2) return 8'(255 - quarter_sample(s - SEGS / 2));
    if (s >= SEGS / 4) return 8'(quarter_sample(SEGS / 2 - s - 1));
    return 8'(quarter_sample(s));
  endfunction

  function automatic logic [7:0] attenuate(logic [7:0] d, logic [3:0] sh);
    if (sh >= 4'd8) return 8'd0;
    return d >> sh;
  endfunction

  function automatic duty_set_t commutate(logic signed [15:0] pos, logic sel, logic [3:0] sh);
    duty_set_t d;
    int seg_c, seg_b, seg_a;
    seg_c = int'(pos) % SEGS;
    if (seg_c < 0) seg_c += SEGS;
    seg_b = seg_c + SEGS / 3;
    if (seg_b >= SEGS) seg_b -= SEGS;
    seg_a = seg_b + SEGS / 3;
    if (seg_a >= SEGS) seg_a -= SEGS;
    d.motor_group = sel;
    d.duty_a = attenuate(sine_duty(seg_a), sh);
    d.duty_b = attenuate(sine_duty(seg_b), sh);
    d.duty_c = attenuate(sine_duty(seg_c), sh);
    return d;
  endfunction

  task automatic report(string msg);
    $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic queue_cmd(int pos, logic sel, logic [3:0] sh, bit hold);
    position_cmd_t c;
    c.position = 16'(pos);
    c.motor_select = sel;
    c.attenuation = sh;
    c.hold_for_idle = hold;
    pending_cmds.push_back(c);
  endtask

  // sender: one beat per queued command, random gap after each, calm stretches with none
  always @(posedge clk_i) begin
    position_cmd_t c;
    bit busy;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      busy = s_axis_tvalid && !s_axis_tready;
      if (!busy) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].hold_for_idle && (results_owed != 0 || s_axis_tvalid))) begin
          c = pending_cmds.pop_front();
          s_axis_tdata <= {4'b0, c.attenuation, c.position};
          s_axis_tuser <= c.motor_select;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          send_gap <= send_calm ? 0 : int'($urandom_range(0, 16));
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall after each result beat
  always @(posedge clk_i) begin
    int n;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      n = recv_calm ? 0 : int'($urandom_range(0, 16));
      m_axis_tready <= (n == 0);
      recv_stall <= n;
    end else if (recv_stall != 0) begin
      if (recv_stall == 1) m_axis_tready <= 1'b1;
      recv_stall <= recv_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor: forecast duties on each input beat, check each output beat in order
  always @(posedge clk_i) begin
    duty_set_t got, want;
    bit took;
    took = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (took) begin
        duty_forecast.push_back(commutate(s_axis_tdata[15:0], s_axis_tuser, s_axis_tdata[19:16]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]};
        if (duty_forecast.size() == 0) begin
          report($sformatf("unexpected duty beat %h group %0d", m_axis_tdata, m_axis_tuser));
        end else begin
          want = duty_forecast.pop_front();
          if (got.motor_group !== want.motor_group)
            report($sformatf("motor_group got %0d want %0d", got.motor_group, want.motor_group));
          if (got.duty_a !== want.duty_a)
            report($sformatf("duty_phase_a got %0d want %0d", got.duty_a, want.duty_a));
          if (got.duty_b !== want.duty_b)
            report($sformatf("duty_phase_b got %0d want %0d", got.duty_b, want.duty_b));
          if (got.duty_c !== want.duty_c)
            report($sformatf("duty_phase_c got %0d want %0d", got.duty_c, want.duty_c));
        end
      end
      results_owed <= duty_forecast.size();
      accepted_beats <= accepted_beats + int'(took);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int pick, pos;
    logic [3:0] sh;

    // directed: field extremes, quadrant edges, phase offsets, negative wrap, every shift
    queue_cmd(0, 1'b0, 4'd0, 1'b0);
    queue_cmd(-32768, 1'b1, 4'd0, 1'b0);
    queue_cmd(32767, 1'b0, 4'd0, 1'b0);
    queue_cmd(-1, 1'b1, 4'd1, 1'b0);
    queue_cmd(1, 1'b0, 4'd2, 1'b0);
    queue_cmd(SEGS - 1, 1'b1, 4'd3, 1'b0);
    queue_cmd(SEGS, 1'b0, 4'd4, 1'b0);
    queue_cmd(-SEGS, 1'b1, 4'd5, 1'b0);
    queue_cmd(QTR - 1, 1'b0, 4'd6, 1'b0);
    queue_cmd(QTR, 1'b1, 4'd7, 1'b0);
    queue_cmd(SEGS / 2 - 1, 1'b0, 4'd0, 1'b0);
    queue_cmd(SEGS / 2, 1'b1, 4'd0, 1'b0);
    queue_cmd(3 * SEGS / 4 - 1, 1'b0, 4'd0, 1'b0);
    queue_cmd(3 * SEGS / 4, 1'b1, 4'd0, 1'b0);
    queue_cmd(SEGS / 3, 1'b0, 4'd0, 1'b0);
    queue_cmd(2 * SEGS / 3, 1'b1, 4'd0, 1'b0);
    queue_cmd(-SEGS / 3 - 1, 1'b0, 4'd8, 1'b0);
    queue_cmd(12345, 1'b1, 4'd9, 1'b0);
    queue_cmd(-12345, 1'b0, 4'd10, 1'b0);
    queue_cmd(SEGS / 2, 1'b1, 4'd11, 1'b0);
    queue_cmd(QTR, 1'b0, 4'd12, 1'b0);
    queue_cmd(3 * QTR, 1'b1, 4'd13, 1'b0);
    queue_cmd(-7, 1'b0, 4'd14, 1'b0);
    queue_cmd(100, 1'b1, 4'd15, 1'b0);

    // random: full-range positions, a few periods around zero, and quadrant and third-period edges
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        pos = int'($signed(16'($urandom)));
      end else if (pick < 7) begin
        pos = int'($urandom_range(0, 4 * SEGS)) - 2 * SEGS;
      end else begin
        pos = landmarks[$urandom_range(0, 5)] + SEGS * (int'($urandom_range(0, 70)) - 35) +
              int'($urandom_range(0, 4)) - 2;
      end
      sh = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(8, 15));
      queue_cmd(pos, 1'($urandom), sh, (i % 175) == 0);
    end
    total_cmds = pending_cmds.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(accepted_beats == total_cmds && duty_forecast.size() == 0)) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (duty_forecast.size() != 0) begin
      report($sformatf("%0d duty sets never came back", duty_forecast.size()));
    end
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
